// ===== rtl/tbc_pkg.sv =====
package tbc_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int QUO_BITS    = 33;
    localparam int WGT_WIDTH   = 32;
    localparam logic [WGT_WIDTH-1:0] WGT_MAX = 32'h7FFF_FFFF;
    localparam logic [WGT_WIDTH-1:0] WGT_MIN = 32'h8000_0000;
    localparam logic signed [WGT_WIDTH+1:0] ONE_Q16 = 34'sd65536;

    typedef struct packed {
        logic                 sat;
        logic [WGT_WIDTH-1:0] value;
    } wgt_t;

    // turn an unsigned quotient, its sign and overflow flag into a clamped weight
    function automatic wgt_t sat_weight(input logic [QUO_BITS-1:0] q, input logic neg,
                                        input logic ovf);
        wgt_t w;
        w.sat   = 1'b0;
        w.value = q[WGT_WIDTH-1:0];
        if (ovf) begin
            w.sat   = 1'b1;
            w.value = neg ? WGT_MIN : WGT_MAX;
        end else if (neg) begin
            if (q > {1'b0, WGT_MIN}) begin
                w.sat   = 1'b1;
                w.value = WGT_MIN;
            end else begin
                w.value = ~q[WGT_WIDTH-1:0] + 1'b1;
            end
        end else if (q > {1'b0, WGT_MAX}) begin
            w.sat   = 1'b1;
            w.value = WGT_MAX;
        end
        return w;
    endfunction

endpackage

// ===== rtl/triangle_barycentric_coords_core.sv =====
// Barycentric weights of a query point against a 2D triangle. Takes one word per clock
// (vertices and point in signed Q12.4) and returns alpha, beta and gamma in signed Q15.16,
// clamped to 32 bits, plus degenerate and saturated flags. Fully pipelined: 4 stages of
// difference/multiply/sum/magnitude, 33 stages of a one-bit-per-stage restoring divider
// (one each for alpha and beta), then 2 stages of clamping and gamma. Throughput is one
// word per cycle; the whole pipeline holds while the output word waits.
module triangle_barycentric_coords_core #(
    parameter int COORD_WIDTH = tbc_pkg::COORD_WIDTH
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // a_x, a_y, b_x, b_y, c_x, c_y, p_x, p_y
    input  logic [8*COORD_WIDTH-1:0] s_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // weight_a, weight_b, weight_c
    output logic [95:0]              m_axis_tdata,
    // degenerate, saturated
    output logic [1:0]               m_axis_tuser
);
    localparam int PW  = 2 * COORD_WIDTH + 3;
    localparam int QB  = tbc_pkg::QUO_BITS;
    localparam int LAT = 4 + QB + 2;

    logic en;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    logic [LAT-1:0] vld_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[LAT-1];

    logic [PW-1:0] na_mag, nb_mag, d_mag;
    logic          na_neg, nb_neg, na_ovf, nb_ovf, degen;

    tbc_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .aclk(aclk), .en(en), .coords(s_axis_tdata),
        .na_mag(na_mag), .nb_mag(nb_mag), .d_mag(d_mag),
        .na_neg(na_neg), .nb_neg(nb_neg), .na_ovf(na_ovf), .nb_ovf(nb_ovf),
        .degen(degen)
    );

    logic [QB-1:0] qa, qb;
    logic          qa_neg, qb_neg, qa_ovf, qb_ovf;

    tbc_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_a (
        .aclk(aclk), .en(en), .n_mag(na_mag), .d_mag(d_mag),
        .neg_in(na_neg), .ovf_in(na_ovf),
        .q_out(qa), .neg_out(qa_neg), .ovf_out(qa_ovf)
    );

    tbc_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_b (
        .aclk(aclk), .en(en), .n_mag(nb_mag), .d_mag(d_mag),
        .neg_in(nb_neg), .ovf_in(nb_ovf),
        .q_out(qb), .neg_out(qb_neg), .ovf_out(qb_ovf)
    );

    // degenerate flag rides alongside the dividers
    logic [QB-1:0] degen_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            degen_reg <= {degen_reg[QB-2:0], degen};
        end
    end

    tbc_back u_back (
        .aclk(aclk), .en(en),
        .qa(qa), .qa_neg(qa_neg), .qa_ovf(qa_ovf),
        .qb(qb), .qb_neg(qb_neg), .qb_ovf(qb_ovf),
        .degen(degen_reg[QB-1]),
        .weights(m_axis_tdata), .flags(m_axis_tuser)
    );

endmodule

// ===== rtl/tbc_front.sv =====
module tbc_front #(
    parameter int COORD_WIDTH = tbc_pkg::COORD_WIDTH,
    localparam int PW = 2 * COORD_WIDTH + 3
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [8*COORD_WIDTH-1:0] coords,
    output logic [PW-1:0]            na_mag,
    output logic [PW-1:0]            nb_mag,
    output logic [PW-1:0]            d_mag,
    output logic                     na_neg,
    output logic                     nb_neg,
    output logic                     na_ovf,
    output logic                     nb_ovf,
    output logic                     degen
);
    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int MW = 2 * W + 2;
    localparam int SH = tbc_pkg::QUO_BITS - tbc_pkg::FRAC_BITS;

    logic signed [W-1:0] ax, ay, bx, by, cx, cy, px, py;
    assign ax = coords[0*W +: W];
    assign ay = coords[1*W +: W];
    assign bx = coords[2*W +: W];
    assign by = coords[3*W +: W];
    assign cx = coords[4*W +: W];
    assign cy = coords[5*W +: W];
    assign px = coords[6*W +: W];
    assign py = coords[7*W +: W];

    // stage 1: coordinate differences
    logic signed [DW-1:0] bycy_reg, cxbx_reg, axcx_reg, aycy_reg, cyay_reg, pxcx_reg, pycy_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            bycy_reg <= DW'(by) - DW'(cy);
            cxbx_reg <= DW'(cx) - DW'(bx);
            axcx_reg <= DW'(ax) - DW'(cx);
            aycy_reg <= DW'(ay) - DW'(cy);
            cyay_reg <= DW'(cy) - DW'(ay);
            pxcx_reg <= DW'(px) - DW'(cx);
            pycy_reg <= DW'(py) - DW'(cy);
        end
    end

    // stage 2: products
    logic signed [MW-1:0] d0_reg, d1_reg, a0_reg, a1_reg, b0_reg, b1_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            d0_reg <= MW'(bycy_reg) * MW'(axcx_reg);
            d1_reg <= MW'(cxbx_reg) * MW'(aycy_reg);
            a0_reg <= MW'(bycy_reg) * MW'(pxcx_reg);
            a1_reg <= MW'(cxbx_reg) * MW'(pycy_reg);
            b0_reg <= MW'(cyay_reg) * MW'(pxcx_reg);
            b1_reg <= MW'(axcx_reg) * MW'(pycy_reg);
        end
    end

    // stage 3: edge function sums
    logic signed [PW-1:0] den_reg, na_reg, nb_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg <= PW'(d0_reg) + PW'(d1_reg);
            na_reg  <= PW'(a0_reg) + PW'(a1_reg);
            nb_reg  <= PW'(b0_reg) + PW'(b1_reg);
        end
    end

    // stage 4: magnitudes, signs and quotient range check
    logic [PW-1:0] na_abs, nb_abs, d_abs;
    assign na_abs = na_reg[PW-1] ? (~na_reg + 1'b1) : na_reg;
    assign nb_abs = nb_reg[PW-1] ? (~nb_reg + 1'b1) : nb_reg;
    assign d_abs  = den_reg[PW-1] ? (~den_reg + 1'b1) : den_reg;

    logic [PW+SH-1:0] d_lim;
    assign d_lim = {d_abs, {SH{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            na_mag <= na_abs;
            nb_mag <= nb_abs;
            d_mag  <= d_abs;
            na_neg <= na_reg[PW-1] ^ den_reg[PW-1];
            nb_neg <= nb_reg[PW-1] ^ den_reg[PW-1];
            na_ovf <= {{SH{1'b0}}, na_abs} >= d_lim;
            nb_ovf <= {{SH{1'b0}}, nb_abs} >= d_lim;
            degen  <= (den_reg == '0);
        end
    end

endmodule

// ===== rtl/tbc_div.sv =====
module tbc_div #(
    parameter int COORD_WIDTH = tbc_pkg::COORD_WIDTH,
    localparam int PW = 2 * COORD_WIDTH + 3,
    localparam int QB = tbc_pkg::QUO_BITS
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [PW-1:0] n_mag,
    input  logic [PW-1:0] d_mag,
    input  logic          neg_in,
    input  logic          ovf_in,
    output logic [QB-1:0] q_out,
    output logic          neg_out,
    output logic          ovf_out
);
    localparam int FB = tbc_pkg::FRAC_BITS;
    localparam int SH = QB - FB;

    // one quotient bit per stage, restoring
    logic [PW-1:0] r_in [0:QB-1];
    logic [PW-1:0] d_in [0:QB-1];
    logic [QB-1:0] x_in [0:QB-1];
    logic [QB-1:0] q_in [0:QB-1];
    logic          s_in [0:QB-1];
    logic          o_in [0:QB-1];

    logic [PW-1:0] r_reg [0:QB-1];
    logic [PW-1:0] d_reg [0:QB-1];
    logic [QB-1:0] x_reg [0:QB-1];
    logic [QB-1:0] q_reg [0:QB-1];
    logic          s_reg [0:QB-1];
    logic          o_reg [0:QB-1];

    assign r_in[0] = n_mag >> SH;
    assign d_in[0] = d_mag;
    assign x_in[0] = {n_mag[SH-1:0], {FB{1'b0}}};
    assign q_in[0] = '0;
    assign s_in[0] = neg_in;
    assign o_in[0] = ovf_in;

    genvar j;
    generate
        for (j = 0; j < QB; j++) begin : g_stage
            logic [PW:0]   rs;
            logic          ge;
            logic [PW:0]   rd;
            assign rs = {r_in[j], x_in[j][QB-1]};
            assign ge = rs >= {1'b0, d_in[j]};
            assign rd = rs - {1'b0, d_in[j]};
            always_ff @(posedge aclk) begin
                if (en) begin
                    r_reg[j] <= ge ? rd[PW-1:0] : rs[PW-1:0];
                    d_reg[j] <= d_in[j];
                    x_reg[j] <= {x_in[j][QB-2:0], 1'b0};
                    q_reg[j] <= {q_in[j][QB-2:0], ge};
                    s_reg[j] <= s_in[j];
                    o_reg[j] <= o_in[j];
                end
            end
            if (j > 0) begin : g_link
                assign r_in[j] = r_reg[j-1];
                assign d_in[j] = d_reg[j-1];
                assign x_in[j] = x_reg[j-1];
                assign q_in[j] = q_reg[j-1];
                assign s_in[j] = s_reg[j-1];
                assign o_in[j] = o_reg[j-1];
            end
        end
    endgenerate

    assign q_out   = q_reg[QB-1];
    assign neg_out = s_reg[QB-1];
    assign ovf_out = o_reg[QB-1];

endmodule

// ===== rtl/tbc_back.sv =====
module tbc_back (
    input  logic                                aclk,
    input  logic                                en,
    input  logic [tbc_pkg::QUO_BITS-1:0]        qa,
    input  logic                                qa_neg,
    input  logic                                qa_ovf,
    input  logic [tbc_pkg::QUO_BITS-1:0]        qb,
    input  logic                                qb_neg,
    input  logic                                qb_ovf,
    input  logic                                degen,
    output logic [3*tbc_pkg::WGT_WIDTH-1:0]     weights,
    output logic [1:0]                          flags
);
    localparam int WW = tbc_pkg::WGT_WIDTH;

    tbc_pkg::wgt_t wa_reg, wb_reg;
    logic          degen_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            wa_reg    <= tbc_pkg::sat_weight(qa, qa_neg, qa_ovf);
            wb_reg    <= tbc_pkg::sat_weight(qb, qb_neg, qb_ovf);
            degen_reg <= degen;
        end
    end

    logic signed [WW+1:0] g;
    logic [WW-1:0]        wc;
    logic                 gsat;
    always_comb begin
        g    = tbc_pkg::ONE_Q16 - (WW+2)'(signed'(wa_reg.value))
                                - (WW+2)'(signed'(wb_reg.value));
        gsat = 1'b0;
        wc   = g[WW-1:0];
        if (g > (WW+2)'(signed'(tbc_pkg::WGT_MAX))) begin
            gsat = 1'b1;
            wc   = tbc_pkg::WGT_MAX;
        end else if (g < (WW+2)'(signed'(tbc_pkg::WGT_MIN))) begin
            gsat = 1'b1;
            wc   = tbc_pkg::WGT_MIN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (degen_reg) begin
                weights <= '0;
                flags   <= 2'b01;
            end else begin
                weights <= {wc, wb_reg.value, wa_reg.value};
                flags   <= {wa_reg.sat | wb_reg.sat | gsat, 1'b0};
            end
        end
    end

endmodule

// ===== rtl/tbc_checker.sv =====
module tbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);
    // a degenerate triangle gives zero weights and no clamp
    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0 && !m_axis_tuser[1]))
        else $error("degenerate word with nonzero weights or clamp");

    // unclamped weights sum to one
    a_sum_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0] && !m_axis_tuser[1]) |->
        (m_axis_tdata[31:0] + m_axis_tdata[63:32] + m_axis_tdata[95:64] == 32'h0001_0000))
        else $error("weights do not sum to one");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled output word changed");

endmodule

bind triangle_barycentric_coords_core tbc_checker u_tbc_checker (
    .aclk(aclk), .aresetn(aresetn),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
